// ===== rtl/core/tmla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmla_pkg
// Types and codes shared by the three-mode lock arbiter modules.
// ----------------------------------------------------------------------------
package tmla_pkg;

	// request operation codes
	localparam logic [3:0] OP_LOCK_RD   = 4'd0;
	localparam logic [3:0] OP_LOCK_WR   = 4'd1;
	localparam logic [3:0] OP_LOCK_EX   = 4'd2;
	localparam logic [3:0] OP_TRY_RD    = 4'd3;
	localparam logic [3:0] OP_TRY_WR    = 4'd4;
	localparam logic [3:0] OP_TRY_EX    = 4'd5;
	localparam logic [3:0] OP_UNLOCK_RD = 4'd6;
	localparam logic [3:0] OP_UNLOCK_WR = 4'd7;
	localparam logic [3:0] OP_UNLOCK_EX = 4'd8;
	localparam logic [3:0] OP_DEMOTE_RD = 4'd9;
	localparam logic [3:0] OP_DEMOTE_WR = 4'd10;

	// lock modes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_EXCL  = 2'd2;

	// result status codes
	localparam logic [3:0] ST_GRANTED  = 4'd0;
	localparam logic [3:0] ST_QUEUED   = 4'd1;
	localparam logic [3:0] ST_REFUSED  = 4'd2;
	localparam logic [3:0] ST_RELEASED = 4'd3;
	localparam logic [3:0] ST_DEMOTED  = 4'd4;
	localparam logic [3:0] ST_WOKEN    = 4'd5;
	localparam logic [3:0] ST_NOT_HELD = 4'd6;
	localparam logic [3:0] ST_Q_FULL   = 4'd7;
	localparam logic [3:0] ST_OVERFLOW = 4'd8;

	// classified command kinds
	localparam logic [1:0] KIND_LOCK   = 2'd0;
	localparam logic [1:0] KIND_TRY    = 2'd1;
	localparam logic [1:0] KIND_UNLOCK = 2'd2;
	localparam logic [1:0] KIND_DEMOTE = 2'd3;

	// width of the reported holder counts
	localparam int CNT_OUT_W = 8;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] ticket;
	} req_t;

	typedef struct packed {
		logic [7:0] ticket_res;
		logic [1:0] mode;
		logic [3:0] status;
		logic [7:0] readers_held;
		logic [7:0] writers_held;
		logic       exclusive_held;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] mode;
		logic [7:0] ticket;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] ticket;
	} q_entry_t;

endpackage

// ===== rtl/core/tmla_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmla_front
// Request intake: decodes an accepted request into a command and hands it
// to the command queue. Undefined operations are dropped here.
// ----------------------------------------------------------------------------
module tmla_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tmla_pkg::req_t      req,
	input  logic                cmd_full,
	output logic                cmd_push,
	output tmla_pkg::cmd_t      cmd,
	output logic                pending
);

	logic           valid_s1;
	tmla_pkg::cmd_t cmd_s1;
	tmla_pkg::cmd_t dec;
	logic           dec_ok;

	always_comb begin
		dec_ok      = 1'b1;
		dec.ticket  = req.ticket;
		dec.kind    = tmla_pkg::KIND_LOCK;
		dec.mode    = tmla_pkg::MODE_READ;
		case (req.operation)
			tmla_pkg::OP_LOCK_RD: begin
				dec.kind = tmla_pkg::KIND_LOCK;   dec.mode = tmla_pkg::MODE_READ;
			end
			tmla_pkg::OP_LOCK_WR: begin
				dec.kind = tmla_pkg::KIND_LOCK;   dec.mode = tmla_pkg::MODE_WRITE;
			end
			tmla_pkg::OP_LOCK_EX: begin
				dec.kind = tmla_pkg::KIND_LOCK;   dec.mode = tmla_pkg::MODE_EXCL;
			end
			tmla_pkg::OP_TRY_RD: begin
				dec.kind = tmla_pkg::KIND_TRY;    dec.mode = tmla_pkg::MODE_READ;
			end
			tmla_pkg::OP_TRY_WR: begin
				dec.kind = tmla_pkg::KIND_TRY;    dec.mode = tmla_pkg::MODE_WRITE;
			end
			tmla_pkg::OP_TRY_EX: begin
				dec.kind = tmla_pkg::KIND_TRY;    dec.mode = tmla_pkg::MODE_EXCL;
			end
			tmla_pkg::OP_UNLOCK_RD: begin
				dec.kind = tmla_pkg::KIND_UNLOCK; dec.mode = tmla_pkg::MODE_READ;
			end
			tmla_pkg::OP_UNLOCK_WR: begin
				dec.kind = tmla_pkg::KIND_UNLOCK; dec.mode = tmla_pkg::MODE_WRITE;
			end
			tmla_pkg::OP_UNLOCK_EX: begin
				dec.kind = tmla_pkg::KIND_UNLOCK; dec.mode = tmla_pkg::MODE_EXCL;
			end
			tmla_pkg::OP_DEMOTE_RD: begin
				dec.kind = tmla_pkg::KIND_DEMOTE; dec.mode = tmla_pkg::MODE_READ;
			end
			tmla_pkg::OP_DEMOTE_WR: begin
				dec.kind = tmla_pkg::KIND_DEMOTE; dec.mode = tmla_pkg::MODE_WRITE;
			end
			default: dec_ok = 1'b0;
		endcase
	end

	assign cmd_push = valid_s1 & ~cmd_full;
	assign cmd      = cmd_s1;
	assign pending  = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= dec_ok;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// ===== rtl/core/tmla_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmla_cmd_fifo
// Two-entry command queue between request intake and the lock engine.
// ----------------------------------------------------------------------------
module tmla_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmla_pkg::cmd_t din,
	input  logic           pop,
	output logic           valid,
	output logic           full,
	output tmla_pkg::cmd_t dout
);

	tmla_pkg::cmd_t slot_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

endmodule

// ===== rtl/core/tmla_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmla_engine
// Lock engine: holder counts, waiter ring and the wake sequencer. A wake
// result is held in hold_q so that the final one can carry the last flag.
// ----------------------------------------------------------------------------
module tmla_engine #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_HOLDERS = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tmla_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output tmla_pkg::res_t res,
	output logic           res_valid,
	output logic           busy
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = OW + 1;
	localparam int CW = $clog2(MAX_HOLDERS + 1);
	localparam int EW = CW + tmla_pkg::CNT_OUT_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WAKE = 1'b1;

	logic              state_q,   state_d;
	logic [CW-1:0]     rd_q,      rd_d;
	logic [CW-1:0]     wr_q,      wr_d;
	logic              ex_q,      ex_d;
	logic [QW-1:0]     head_q,    head_d;
	logic [OW-1:0]     occ_q,     occ_d;
	logic              have_q,    have_d;
	logic [1:0]        kind_q,    kind_d;
	tmla_pkg::res_t    hold_q,    hold_d;
	tmla_pkg::res_t    out_q,     out_d;
	logic              outv_q,    outv_d;

	tmla_pkg::q_entry_t mem [QUEUE_DEPTH];
	tmla_pkg::q_entry_t rdata_q;
	tmla_pkg::q_entry_t wdata;
	logic               we;
	logic [QW-1:0]      waddr;
	logic [QW-1:0]      raddr;

	logic [QW-1:0]  head_nx;
	logic [TW-1:0]  tail_sum;
	logic [CW-1:0]  cur_cnt;
	logic [CW-1:0]  oth_cnt;
	logic [CW-1:0]  wk_cnt;
	logic           ok;
	logic           wake_go;
	logic           stop;
	logic [7:0]     r_tk;
	logic [1:0]     r_md;
	logic [3:0]     r_st;
	logic [EW-1:0]  rd_ext;
	logic [EW-1:0]  wr_ext;
	tmla_pkg::res_t res_new;

	assign head_nx  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum = TW'(head_q) + TW'(occ_q);
	assign waddr    = (tail_sum >= TW'(QUEUE_DEPTH)) ? QW'(tail_sum - TW'(QUEUE_DEPTH))
	                                                 : QW'(tail_sum);
	assign wdata.mode   = cmd.mode;
	assign wdata.ticket = cmd.ticket;

	assign cur_cnt = (cmd.mode == tmla_pkg::MODE_READ) ? rd_q : wr_q;
	assign oth_cnt = (cmd.mode == tmla_pkg::MODE_READ) ? wr_q : rd_q;
	assign wk_cnt  = (rdata_q.mode == tmla_pkg::MODE_READ) ? rd_q : wr_q;

	assign cmd_pop = cmd_valid & (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		rd_d    = rd_q;
		wr_d    = wr_q;
		ex_d    = ex_q;
		head_d  = head_q;
		occ_d   = occ_q;
		have_d  = have_q;
		kind_d  = kind_q;
		hold_d  = hold_q;
		out_d   = out_q;
		outv_d  = 1'b0;
		we      = 1'b0;
		raddr   = head_q;
		ok      = 1'b0;
		wake_go = 1'b0;
		stop    = 1'b0;
		r_tk    = cmd.ticket;
		r_md    = cmd.mode;
		r_st    = tmla_pkg::ST_GRANTED;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						tmla_pkg::KIND_LOCK, tmla_pkg::KIND_TRY: begin
							if (cmd.mode == tmla_pkg::MODE_EXCL) begin
								ok = (rd_q == '0) && (wr_q == '0) && !ex_q;
							end else begin
								ok = (oth_cnt == '0) && !ex_q && (occ_q == '0);
							end
							if (ok) begin
								if (cmd.mode == tmla_pkg::MODE_EXCL) begin
									ex_d = 1'b1;
								end else if (cur_cnt >= CW'(MAX_HOLDERS)) begin
									r_st = tmla_pkg::ST_OVERFLOW;
								end else if (cmd.mode == tmla_pkg::MODE_READ) begin
									rd_d = rd_q + 1'b1;
								end else begin
									wr_d = wr_q + 1'b1;
								end
							end else if (cmd.kind == tmla_pkg::KIND_TRY) begin
								r_st = tmla_pkg::ST_REFUSED;
							end else if (occ_q == OW'(QUEUE_DEPTH)) begin
								r_st = tmla_pkg::ST_Q_FULL;
							end else begin
								we    = 1'b1;
								occ_d = occ_q + 1'b1;
								r_st  = tmla_pkg::ST_QUEUED;
							end
						end
						tmla_pkg::KIND_UNLOCK: begin
							if (cmd.mode == tmla_pkg::MODE_EXCL) begin
								if (!ex_q) begin
									r_st = tmla_pkg::ST_NOT_HELD;
								end else begin
									ex_d    = 1'b0;
									r_st    = tmla_pkg::ST_RELEASED;
									wake_go = 1'b1;
								end
							end else if (cur_cnt == '0) begin
								r_st = tmla_pkg::ST_NOT_HELD;
							end else begin
								r_st    = tmla_pkg::ST_RELEASED;
								wake_go = (cur_cnt == CW'(1));
								if (cmd.mode == tmla_pkg::MODE_READ) begin
									rd_d = rd_q - 1'b1;
								end else begin
									wr_d = wr_q - 1'b1;
								end
							end
						end
						default: begin
							if (!ex_q) begin
								r_st = tmla_pkg::ST_NOT_HELD;
							end else begin
								ex_d = 1'b0;
								r_st = tmla_pkg::ST_DEMOTED;
								if (cmd.mode == tmla_pkg::MODE_READ) begin
									rd_d = rd_q + 1'b1;
								end else begin
									wr_d = wr_q + 1'b1;
								end
							end
						end
					endcase
				end
			end
			S_WAKE: begin
				r_tk = rdata_q.ticket;
				r_md = rdata_q.mode;
				r_st = tmla_pkg::ST_WOKEN;
				stop = (occ_q == '0)
				    || (have_q && ((kind_q == tmla_pkg::MODE_EXCL) || (rdata_q.mode != kind_q)))
				    || ((rdata_q.mode != tmla_pkg::MODE_EXCL) && (wk_cnt >= CW'(MAX_HOLDERS)));
				if (!stop) begin
					if (rdata_q.mode == tmla_pkg::MODE_EXCL) begin
						ex_d = 1'b1;
					end else if (rdata_q.mode == tmla_pkg::MODE_READ) begin
						rd_d = rd_q + 1'b1;
					end else begin
						wr_d = wr_q + 1'b1;
					end
					head_d = head_nx;
					occ_d  = occ_q - 1'b1;
					have_d = 1'b1;
					kind_d = rdata_q.mode;
					// prefetch the next waiter so one grant goes out per cycle
					raddr  = head_nx;
				end
			end
			default: state_d = S_IDLE;
		endcase

		rd_ext = {{tmla_pkg::CNT_OUT_W{1'b0}}, rd_d};
		wr_ext = {{tmla_pkg::CNT_OUT_W{1'b0}}, wr_d};
		res_new.ticket_res     = r_tk;
		res_new.mode           = r_md;
		res_new.status         = r_st;
		res_new.readers_held   = rd_ext[tmla_pkg::CNT_OUT_W-1:0];
		res_new.writers_held   = wr_ext[tmla_pkg::CNT_OUT_W-1:0];
		res_new.exclusive_held = ex_d;
		res_new.last           = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (wake_go && (occ_q != '0)) begin
						// first waiter is always granted, so the ack is not last
						hold_d      = res_new;
						hold_d.last = 1'b0;
						have_d      = 1'b0;
						state_d     = S_WAKE;
					end else begin
						out_d  = res_new;
						outv_d = 1'b1;
					end
				end
			end
			S_WAKE: begin
				out_d  = hold_q;
				outv_d = 1'b1;
				if (stop) begin
					out_d.last = 1'b1;
					state_d    = S_IDLE;
				end else begin
					out_d.last  = 1'b0;
					hold_d      = res_new;
					hold_d.last = 1'b0;
				end
			end
			default: outv_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_q    <= '0;
			wr_q    <= '0;
			ex_q    <= 1'b0;
			head_q  <= '0;
			occ_q   <= '0;
			have_q  <= 1'b0;
			kind_q  <= tmla_pkg::MODE_READ;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			ex_q    <= ex_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			have_q  <= have_d;
			kind_q  <= kind_d;
			outv_q  <= outv_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold_d;
		out_q  <= out_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign res       = out_q;
	assign res_valid = outv_q;
	assign busy      = (state_q != S_IDLE);

endmodule

// ===== rtl/core/three_mode_lock_arbiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_mode_lock_arbiter
// Read / write / exclusive lock with a FIFO of blocked waiters.
//
//   channel   ports                  transfer
//   -------   --------------------   ---------------------------------
//   request   start, busy, req       edge with start high, busy low
//   result    res_valid, res         every edge with res_valid high
//
// A request passes from transfer to its acknowledgment through the intake
// register, the command queue, then the lock engine into the result
// register. An unlock that frees the lock is followed by one result per
// woken waiter, the final one carrying the last flag; the waiter ring is
// read one entry per cycle with the next entry fetched ahead. busy stays
// high until the final result of a request is on the result ports.
// Reset clears holder counts, the waiter ring pointers and all control
// state; ring contents are not cleared. Results cannot be held off.
// ----------------------------------------------------------------------------
module three_mode_lock_arbiter #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_HOLDERS = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tmla_pkg::req_t req,
	output logic           res_valid,
	output tmla_pkg::res_t res
);

	logic           take;
	logic           front_pending;
	logic           push;
	tmla_pkg::cmd_t front_cmd;
	logic           fifo_valid;
	logic           fifo_full;
	tmla_pkg::cmd_t fifo_cmd;
	logic           pop;
	logic           engine_busy;

	assign take = start & ~busy;
	assign busy = front_pending | fifo_valid | engine_busy;

	tmla_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req      (req),
		.cmd_full (fifo_full),
		.cmd_push (push),
		.cmd      (front_cmd),
		.pending  (front_pending)
	);

	tmla_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_cmd),
		.pop    (pop),
		.valid  (fifo_valid),
		.full   (fifo_full),
		.dout   (fifo_cmd)
	);

	tmla_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_HOLDERS (MAX_HOLDERS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (fifo_valid),
		.cmd       (fifo_cmd),
		.cmd_pop   (pop),
		.res       (res),
		.res_valid (res_valid),
		.busy      (engine_busy)
	);

endmodule
